@@ rtl/core/pmst_pkg.sv @@
// Shared constants and controller/datapath interface types for the spanning tree block.
package pmst_pkg;

	localparam int MAX_VERTICES_DEF = 16;
	localparam int WEIGHT_BITS_DEF  = 8;

	localparam int VTX_FIELD_W = 4;
	localparam int WGT_FIELD_W = 8;
	localparam int CFG_W       = 5;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	localparam logic [CFG_W-1:0] VIU_RESET = 5'd16;
	localparam logic             REG_VIU   = 1'b0;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_SOLVE = 1'b1;

	typedef struct packed {
		logic clear_en;
		logic wr_en;
		logic start;
		logic scan_en;
		logic emit;
	} pmst_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic col_last;
		logic best_found;
		logic run_last;
	} pmst_status_t;

endpackage

@@ rtl/core/pmst_ram.sv @@
// Generic single write port RAM with one registered read port.
module pmst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/pmst_ctrl.sv @@
// Controller state machine: clearing pass, item intake, row scans and result hand-off.
module pmst_ctrl import pmst_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_valid,
	input  logic         s_mode,
	output logic         s_ready,
	output logic         m_valid,
	input  logic         m_ready,
	input  pmst_status_t status,
	output pmst_cmd_t    cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       accept;

	assign s_ready = (state_q == ST_IDLE);
	assign m_valid = out_valid_q;
	assign accept  = s_valid && s_ready;

	always_comb begin
		cmd          = '0;
		cmd.clear_en = (state_q == ST_CLEAR);
		cmd.wr_en    = accept && (s_mode == MODE_WRITE);
		cmd.start    = accept && (s_mode == MODE_SOLVE);
		cmd.scan_en  = (state_q == ST_SCAN);
		cmd.emit     = (state_q == ST_EMIT) && (!out_valid_q || m_ready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd.start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.col_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (cmd.emit) begin
					// A disconnected result or the final edge ends the run.
					if (!status.best_found || status.run_last) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/pmst_dp.sv @@
// Datapath: weight matrix, per-vertex key ring, row scan compare and result register.
module pmst_dp import pmst_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pmst_cmd_t              cmd,
	output pmst_status_t           status,
	input  logic [VTX_FIELD_W-1:0] row_vertex,
	input  logic [VTX_FIELD_W-1:0] col_vertex,
	input  logic [WGT_FIELD_W-1:0] edge_weight,
	input  logic [CFG_W-1:0]       vertices_in_use,
	output logic [VTX_FIELD_W-1:0] from_vertex,
	output logic [VTX_FIELD_W-1:0] to_vertex,
	output logic [WGT_FIELD_W-1:0] tree_weight,
	output logic                   disconnected,
	output logic                   last_edge
);

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int NW    = VW + 1;
	localparam int AW    = 2 * VW;
	localparam int DEPTH = 1 << AW;
	localparam int M     = MAX_VERTICES;
	localparam int WB    = WEIGHT_BITS;

	// Matrix store and its clearing counter.
	logic [AW-1:0] clr_q;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [WB-1:0] ram_wdata;
	logic [WB-1:0] ram_rdata;

	logic [VW+3:0]          row_x;
	logic [VW+3:0]          col_x;
	logic [WB+7:0]          wgt_x;
	logic                   in_range;

	// Run state.
	logic [VW-1:0] j_q;
	logic [VW-1:0] j_s1;
	logic          rd_valid_s1;
	logic [VW-1:0] v_q;
	logic [VW-1:0] edges_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] n_sat;
	logic [NW+4:0] viu_x;
	logic [M-1:0]  in_tree_q;

	// Key ring: entry 0 is the column currently coming out of the store.
	logic          key_has_q [M];
	logic [WB-1:0] key_w_q   [M];
	logic [VW-1:0] key_par_q [M];

	logic          best_has_q;
	logic [WB-1:0] best_w_q;
	logic [VW-1:0] best_par_q;
	logic [VW-1:0] best_j_q;

	logic          cand;
	logic          better;
	logic          take;
	logic          nk_has;
	logic [WB-1:0] nk_w;
	logic [VW-1:0] nk_par;
	logic          elig;
	logic          sel;

	logic [VW+3:0] par_x;
	logic [VW+3:0] bj_x;
	logic [WB+7:0] bw_x;

	assign row_x    = {{VW{1'b0}}, row_vertex};
	assign col_x    = {{VW{1'b0}}, col_vertex};
	assign wgt_x    = {{WB{1'b0}}, edge_weight};
	assign in_range = (row_x < (VW + 4)'(M)) && (col_x < (VW + 4)'(M));

	assign ram_we    = cmd.clear_en || (cmd.wr_en && in_range);
	assign ram_waddr = cmd.clear_en ? clr_q : {row_x[VW-1:0], col_x[VW-1:0]};
	assign ram_wdata = cmd.clear_en ? '0 : wgt_x[WB-1:0];

	pmst_ram #(
		.WIDTH(WB),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr({v_q, j_q}),
		.rdata(ram_rdata)
	);

	assign viu_x = {{NW{1'b0}}, vertices_in_use};

	always_comb begin
		if (viu_x < (NW + 5)'(2)) begin
			n_sat = NW'(2);
		end else if (viu_x > (NW + 5)'(M)) begin
			n_sat = NW'(M);
		end else begin
			n_sat = viu_x[NW-1:0];
		end
	end

	// Relax the key of the column in hand against the new tree vertex, then
	// check it against the lightest crossing edge seen so far in this scan.
	always_comb begin
		cand   = ({1'b0, j_s1} < n_q) && !in_tree_q[j_s1] && (ram_rdata != '0);
		better = !key_has_q[0] || (ram_rdata < key_w_q[0])
			|| ((ram_rdata == key_w_q[0]) && (v_q < key_par_q[0]));
		take   = cand && better;
		nk_has = take || key_has_q[0];
		nk_w   = take ? ram_rdata : key_w_q[0];
		nk_par = take ? v_q : key_par_q[0];
		elig   = ({1'b0, j_s1} < n_q) && !in_tree_q[j_s1] && nk_has;
		sel    = elig && (!best_has_q || (nk_w < best_w_q)
			|| ((nk_w == best_w_q) && (nk_par < best_par_q)));
	end

	assign status.clear_done = &clr_q;
	assign status.col_last   = (j_q == VW'(M - 1));
	assign status.best_found = best_has_q;
	assign status.run_last   = (({1'b0, edges_q} + NW'(2)) == n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			j_q         <= '0;
			rd_valid_s1 <= 1'b0;
			v_q         <= '0;
			edges_q     <= '0;
			n_q         <= NW'(2);
			in_tree_q   <= '0;
			best_has_q  <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan_en;
			if (cmd.clear_en) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.scan_en) begin
				j_q <= status.col_last ? '0 : j_q + VW'(1);
			end
			if (cmd.start) begin
				v_q        <= '0;
				edges_q    <= '0;
				n_q        <= n_sat;
				in_tree_q  <= M'(1);
				best_has_q <= 1'b0;
			end else if (cmd.emit) begin
				best_has_q <= 1'b0;
				if (best_has_q) begin
					in_tree_q[best_j_q] <= 1'b1;
					v_q                 <= best_j_q;
					edges_q             <= edges_q + VW'(1);
				end
			end else if (rd_valid_s1 && sel) begin
				best_has_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < M; k++) begin
				key_has_q[k] <= 1'b0;
			end
		end else if (cmd.start) begin
			for (int k = 0; k < M; k++) begin
				key_has_q[k] <= 1'b0;
			end
		end else if (rd_valid_s1) begin
			for (int k = 0; k < M - 1; k++) begin
				key_has_q[k] <= key_has_q[k + 1];
			end
			key_has_q[M - 1] <= nk_has;
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= j_q;
		if (rd_valid_s1) begin
			for (int k = 0; k < M - 1; k++) begin
				key_w_q[k]   <= key_w_q[k + 1];
				key_par_q[k] <= key_par_q[k + 1];
			end
			key_w_q[M - 1]   <= nk_w;
			key_par_q[M - 1] <= nk_par;
			if (sel) begin
				best_w_q   <= nk_w;
				best_par_q <= nk_par;
				best_j_q   <= j_s1;
			end
		end
	end

	assign par_x = {4'b0, best_par_q};
	assign bj_x  = {4'b0, best_j_q};
	assign bw_x  = {8'b0, best_w_q};

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (best_has_q) begin
				from_vertex  <= par_x[VTX_FIELD_W-1:0];
				to_vertex    <= bj_x[VTX_FIELD_W-1:0];
				tree_weight  <= bw_x[WGT_FIELD_W-1:0];
				disconnected <= 1'b0;
				last_edge    <= status.run_last;
			end else begin
				from_vertex  <= '0;
				to_vertex    <= '0;
				tree_weight  <= '0;
				disconnected <= 1'b1;
				last_edge    <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/prim_minimum_spanning_tree.sv @@
// A solve gives one edge item per round: a full row scan of the matrix RAM read port, a
// drain state and an emit state; a solve runs for up to n - 1 such rounds.
// Throughput: one item at a time; the next item is taken once the last result is queued.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes all 2^(2*ceil(log2
// MAX_VERTICES)) matrix entries (256 by default) with s_axis_tready low.
module prim_minimum_spanning_tree import pmst_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata,  // row_vertex, col_vertex, edge_weight
	input  logic                  s_axis_tuser,  // mode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [15:0]           m_axis_tdata,  // from_vertex, to_vertex, tree_weight
	output logic                  m_axis_tuser,  // disconnected
	output logic                  m_axis_tlast   // last_edge
);

	logic [CFG_W-1:0]       vertices_q;
	pmst_cmd_t              cmd;
	pmst_status_t           status;
	logic [VTX_FIELD_W-1:0] from_vertex;
	logic [VTX_FIELD_W-1:0] to_vertex;
	logic [WGT_FIELD_W-1:0] tree_weight;

	assign pready = 1'b1;
	assign prdata = (paddr[APB_ADDR_W-1:2] == REG_VIU)
		? {{(APB_DATA_W - CFG_W){1'b0}}, vertices_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertices_q <= VIU_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr[APB_ADDR_W-1:2] == REG_VIU)) begin
			vertices_q <= pwdata[CFG_W-1:0];
		end
	end

	pmst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.s_valid(s_axis_tvalid),
		.s_mode (s_axis_tuser),
		.s_ready(s_axis_tready),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.status (status),
		.cmd    (cmd)
	);

	pmst_dp #(
		.MAX_VERTICES(MAX_VERTICES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.row_vertex     (s_axis_tdata[3:0]),
		.col_vertex     (s_axis_tdata[7:4]),
		.edge_weight    (s_axis_tdata[15:8]),
		.vertices_in_use(vertices_q),
		.from_vertex    (from_vertex),
		.to_vertex      (to_vertex),
		.tree_weight    (tree_weight),
		.disconnected   (m_axis_tuser),
		.last_edge      (m_axis_tlast)
	);

	assign m_axis_tdata = {tree_weight, to_vertex, from_vertex};

endmodule

@@ rtl/core/pmst_checker.sv @@
// Port-level checker for the spanning tree block, bound to the top level.
module pmst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);

	// A disconnected result always closes the run.
	a_disc_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("disconnected result without last marker");

	// A disconnected result carries no edge.
	a_disc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == 16'd0))
		else $error("disconnected result carries edge data");

	// A real tree edge never has weight zero.
	a_edge_weight: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[15:8] != 8'd0))
		else $error("tree edge with zero weight");

	// Once a solve item is taken, the block is busy on the next cycle.
	a_solve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
		else $error("input taken right after a solve item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind prim_minimum_spanning_tree pmst_checker u_pmst_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

@@ tb/sv/prim_minimum_spanning_tree_tb.sv @@
// Self-checking testbench for the Prim spanning tree block: stream stimulus, APB setup, scoreboard.
`timescale 1ns / 100ps

module prim_minimum_spanning_tree_tb;
	import pmst_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 2 * MAX_VERTICES_DEF + 8;
	localparam int TARGET_ITEMS = 450;
	localparam logic [APB_ADDR_W-1:0] VIU_ADDR = APB_ADDR_W'(4 * REG_VIU);

	typedef struct packed {
		logic [VTX_FIELD_W-1:0] from_vertex;
		logic [VTX_FIELD_W-1:0] to_vertex;
		logic [WGT_FIELD_W-1:0] tree_weight;
		logic                   disconnected;
		logic                   last_edge;
	} tree_edge_t;

	// Keeps a private copy of the matrix and the vertex count and predicts the edge items.
	class mst_scoreboard;
		logic [WGT_FIELD_W-1:0] edge_weights [MAX_VERTICES_DEF][MAX_VERTICES_DEF];
		logic [CFG_W-1:0] vertex_count;
		tree_edge_t pending_edges[$];
		int errors;

		function new();
			foreach (edge_weights[i, j])
				edge_weights[i][j] = '0;
			vertex_count = VIU_RESET;
			errors = 0;
		endfunction

		function void set_vertex_count(logic [CFG_W-1:0] count);
			vertex_count = count;
		endfunction

		function int pending();
			return pending_edges.size();
		endfunction

		function void note_item(logic mode, logic [VTX_FIELD_W-1:0] row,
				logic [VTX_FIELD_W-1:0] col, logic [WGT_FIELD_W-1:0] wgt);
			int n;
			int emitted;
			int bi;
			int bj;
			bit found;
			logic [WGT_FIELD_W-1:0] best;
			logic [MAX_VERTICES_DEF-1:0] in_tree;
			tree_edge_t res;
			if (mode == MODE_WRITE) begin
				edge_weights[row][col] = wgt;
				return;
			end
			n = vertex_count;
			if (n < 2)
				n = 2;
			if (n > MAX_VERTICES_DEF)
				n = MAX_VERTICES_DEF;
			in_tree = 1;
			emitted = 0;
			while (emitted < n - 1) begin
				found = 0;
				best = '0;
				bi = 0;
				bj = 0;
				for (int i = 0; i < n; i++) begin
					if (!in_tree[i])
						continue;
					for (int j = 0; j < n; j++) begin
						if (in_tree[j] || edge_weights[i][j] == 0)
							continue;
						if (!found || edge_weights[i][j] < best) begin
							found = 1;
							best = edge_weights[i][j];
							bi = i;
							bj = j;
						end
					end
				end
				if (!found) begin
					res.from_vertex = '0;
					res.to_vertex = '0;
					res.tree_weight = '0;
					res.disconnected = 1'b1;
					res.last_edge = 1'b1;
					pending_edges.push_back(res);
					return;
				end
				in_tree[bj] = 1'b1;
				emitted++;
				res.from_vertex = bi[VTX_FIELD_W-1:0];
				res.to_vertex = bj[VTX_FIELD_W-1:0];
				res.tree_weight = best;
				res.disconnected = 1'b0;
				res.last_edge = (emitted == n - 1);
				pending_edges.push_back(res);
			end
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_edge(tree_edge_t got);
			tree_edge_t want;
			if (pending_edges.size() == 0) begin
				errors++;
				$display("%0t: unexpected item from=%0d to=%0d w=%0d disc=%0b last=%0b",
					$time, got.from_vertex, got.to_vertex, got.tree_weight,
					got.disconnected, got.last_edge);
				return;
			end
			want = pending_edges.pop_front();
			compare_field("from_vertex", 8'(want.from_vertex), 8'(got.from_vertex));
			compare_field("to_vertex", 8'(want.to_vertex), 8'(got.to_vertex));
			compare_field("tree_weight", want.tree_weight, got.tree_weight);
			compare_field("disconnected", 8'(want.disconnected), 8'(got.disconnected));
			compare_field("last_edge", 8'(want.last_edge), 8'(got.last_edge));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // row_vertex, col_vertex, edge_weight
	logic s_axis_tuser = 1'b0;       // mode
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;       // from_vertex, to_vertex, tree_weight
	logic m_axis_tuser;              // disconnected
	logic m_axis_tlast;              // last_edge

	mst_scoreboard sb = new();
	tree_edge_t got_edge;
	bit steady_flow = 1'b0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int items_sent = 0;

	prim_minimum_spanning_tree DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one; none at all in a steady stretch.
	function automatic int idle_gap();
		int r;
		if (steady_flow)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_axis_tready <= 1'b1;
			stall_left <= idle_gap();
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			got_edge.from_vertex = m_axis_tdata[3:0];
			got_edge.to_vertex = m_axis_tdata[7:4];
			got_edge.tree_weight = m_axis_tdata[15:8];
			got_edge.disconnected = m_axis_tuser;
			got_edge.last_edge = m_axis_tlast;
			sb.check_edge(got_edge);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_item(input logic mode, input logic [3:0] row, input logic [3:0] col,
			input logic [7:0] wgt);
		int gap;
		gap = idle_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tuser <= mode;
		s_axis_tdata <= {wgt, col, row};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(mode, row, col, wgt);
		items_sent++;
	endtask

	// Holds the stream until every predicted edge item has been taken, then lets the block settle.
	task automatic drain_stream();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [CFG_W-1:0] count);
		logic [APB_DATA_W-1:0] word;
		word = $urandom();
		word[CFG_W-1:0] = count;
		drain_stream();
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= VIU_ADDR;
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[CFG_W-1:0] !== count) begin
			sb.errors++;
			$display("%0t: vertices_in_use readback expected %0d, got %0d",
				$time, count, prdata[CFG_W-1:0]);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_vertex_count(count);
	endtask

	task automatic send_solve();
		send_item(MODE_SOLVE, 4'($urandom), 4'($urandom), 8'($urandom));
	endtask

	initial begin
		int cfg;
		int nn;
		int wmax;
		int shape;
		int u;
		int v;
		int w;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty matrix: the very first round finds no crossing edge.
		send_solve();
		// One-way entry from vertex 0, and a self loop that never crosses the cut.
		send_item(MODE_WRITE, 4'd0, 4'd15, 8'd1);
		send_item(MODE_WRITE, 4'd15, 4'd15, 8'd255);
		send_solve();
		// Equal weights from vertex 0 pick the lower column first.
		send_item(MODE_WRITE, 4'd0, 4'd1, 8'd7);
		send_item(MODE_WRITE, 4'd0, 4'd2, 8'd7);
		send_item(MODE_WRITE, 4'd1, 4'd0, 8'd0);
		send_item(MODE_WRITE, 4'd2, 4'd3, 8'd255);
		send_solve();
		send_solve();
		write_vertex_count(5'd2);
		send_solve();
		write_vertex_count(5'd0);
		send_solve();
		write_vertex_count(5'd1);
		send_solve();
		write_vertex_count(5'd17);
		send_solve();
		write_vertex_count(5'd31);
		send_item(MODE_WRITE, 4'd15, 4'd0, 8'd128);
		send_solve();
		write_vertex_count(5'd16);
		send_solve();

		while (items_sent < TARGET_ITEMS) begin
			w = $urandom_range(0, 9);
			if (w < 7)
				cfg = $urandom_range(2, 16);
			else if (w == 7)
				cfg = 2;
			else if (w == 8)
				cfg = 16;
			else if ($urandom_range(0, 1) == 0)
				cfg = $urandom_range(0, 1);
			else
				cfg = $urandom_range(17, 31);
			nn = cfg < 2 ? 2 : (cfg > MAX_VERTICES_DEF ? MAX_VERTICES_DEF : cfg);
			write_vertex_count(cfg[CFG_W-1:0]);
			steady_flow = ($urandom_range(0, 4) == 0);
			wmax = ($urandom_range(0, 2) == 0) ? 3 : 255;
			shape = $urandom_range(0, 9);
			if (shape < 8) begin
				// A random spanning tree over the active vertices, then extra chords.
				for (v = 1; v < nn; v++) begin
					u = $urandom_range(0, v - 1);
					w = $urandom_range(1, wmax);
					send_item(MODE_WRITE, u[3:0], v[3:0], w[7:0]);
					send_item(MODE_WRITE, v[3:0], u[3:0], w[7:0]);
				end
				repeat ($urandom_range(0, 6)) begin
					u = $urandom_range(0, nn - 1);
					v = $urandom_range(0, nn - 1);
					w = $urandom_range(0, wmax);
					send_item(MODE_WRITE, u[3:0], v[3:0], w[7:0]);
					send_item(MODE_WRITE, v[3:0], u[3:0], w[7:0]);
				end
				if (shape == 7) begin
					// Break the graph: drop one edge entirely and leave another one-way.
					u = $urandom_range(0, nn - 1);
					v = $urandom_range(0, nn - 1);
					send_item(MODE_WRITE, u[3:0], v[3:0], 8'd0);
					send_item(MODE_WRITE, v[3:0], u[3:0], 8'd0);
					send_item(MODE_WRITE, 4'($urandom_range(0, nn - 1)),
						4'($urandom_range(0, nn - 1)), 8'd0);
				end
			end else begin
				repeat ($urandom_range(3, 15))
					send_item(MODE_WRITE, 4'($urandom), 4'($urandom), 8'($urandom));
			end
			send_solve();
			if ($urandom_range(0, 2) == 0)
				send_solve();
		end

		steady_flow = 1'b0;
		drain_stream();
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
